### rtl/lnb_pkg.sv
// ----------------------------------------------------------------------------
// Trailing-lines buffer package
// Shared widths, constants and word types for the trailing-lines buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lnb_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;   // stored line length
    localparam int SHOW_W = 8;   // lines_to_show register

    localparam int DEF_MAX_LINES = 128;
    localparam int DEF_LINE_LEN  = 128;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [SHOW_W-1:0] DEFAULT_SHOW = 8'd10;

    // command word handed from the front queue to the engine
    typedef struct packed {
        logic              is_pull;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    // result word
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              last_byte;
    } t_res;

endpackage

`default_nettype wire

### rtl/last_n_lines_buffer.sv
// ----------------------------------------------------------------------------
// Trailing-lines buffer, top level
// Keeps the most recent lines of a byte stream and replays them on request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave: tuser[0] = opcode (0 push tdata[7:0] as a text byte, 1 pull the
//   next replay byte). Master: one word per pull, none per push; tdata[7:0]
//   = byte, tuser[0] = byte valid, tlast = final byte of the replay; an
//   exhausted replay answers with an empty word until the next push.
//   Config sets lines_to_show (0 or above MAX_LINES: all); the user must
//   write it only while idle; the block itself does not enforce this.
// Sequence, from the engine taking a word off the input queue: a push is
//   stored while idle. A pull fetches its byte (BYTE) and registers it for
//   output (OUT); a byte that ends a line also reads the next slot length
//   (LEN_NEXT). The first pull of a replay closes a pending partial line
//   and reads the first slot length (OPEN, LEN_START); an empty one goes
//   from OPEN to OUT. The next word is taken the cycle after the result is
//   accepted. A stalled receiver holds the output word; the two-word input
//   queue fills; s_axis_tready drops. Reset empties ring and queue, show = 10.
// ----------------------------------------------------------------------------
`default_nettype none

module last_n_lines_buffer #(
    parameter int MAX_LINES = lnb_pkg::DEF_MAX_LINES,
    parameter int LINE_LEN  = lnb_pkg::DEF_LINE_LEN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input words
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_axis_tuser,   // [0] opcode
    // result words
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [0:0]      m_axis_tuser,   // [0] has_byte
    output logic            m_axis_tlast,   // last_byte
    // lines_to_show write channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);
    import lnb_pkg::*;

    logic [SHOW_W-1:0] r_show;
    logic              cmd_valid, cmd_ready;
    t_cmd              cmd;
    t_res              res;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show <= DEFAULT_SHOW;
        end else if (i_cfg_valid) begin
            r_show <= i_cfg_data;
        end
    end

    lnb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (s_axis_tuser[0]),
        .i_data_byte (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    lnb_engine #(
        .MAX_LINES (MAX_LINES),
        .LINE_LEN  (LINE_LEN)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_show      (r_show),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata    = res.out_byte;
    assign m_axis_tuser[0] = res.has_byte;
    assign m_axis_tlast    = res.last_byte;

endmodule

`default_nettype wire

### rtl/lnb_front.sv
// ----------------------------------------------------------------------------
// Trailing-lines buffer front end
// Accepts input words, decodes push/pull and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module lnb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_opcode,
    input  wire logic [7:0]    i_data_byte,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output lnb_pkg::t_cmd      o_cmd
);
    import lnb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;
    t_cmd       in_cmd;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    // classify: opcode 1 is a pull request, its data byte is don't-care
    always_comb begin
        in_cmd.is_pull = i_opcode;
        in_cmd.data    = i_data_byte;
    end

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/lnb_engine.sv
// ----------------------------------------------------------------------------
// Trailing-lines buffer engine
// Line store, slot lengths, ring pointers and the replay sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lnb_engine #(
    parameter int MAX_LINES = lnb_pkg::DEF_MAX_LINES,
    parameter int LINE_LEN  = lnb_pkg::DEF_LINE_LEN
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [lnb_pkg::SHOW_W-1:0] i_show,
    input  wire logic                      i_cmd_valid,
    output logic                           o_cmd_ready,
    input  wire lnb_pkg::t_cmd             i_cmd,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output lnb_pkg::t_res                  o_res
);
    import lnb_pkg::*;

    localparam int SLOT_W  = $clog2(MAX_LINES);
    localparam int OFF_W   = $clog2(LINE_LEN);
    localparam int CNT_W   = $clog2(MAX_LINES + 1);
    localparam int ADDR_W  = SLOT_W + OFF_W;
    localparam int STORE_D = MAX_LINES * (2 ** OFF_W);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_OPEN      = 6'b000010,
        S_LEN_START = 6'b000100,
        S_BYTE      = 6'b001000,
        S_LEN_NEXT  = 6'b010000,
        S_OUT       = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_ws, n_ws;
    logic [OFF_W-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0]    r_seen, n_seen;
    logic                r_active, n_active;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [LEN_W-1:0]    r_cur_len, n_cur_len;
    t_res                r_res, n_res;

    // memories
    logic [BYTE_W-1:0]   r_store [STORE_D];
    logic [LEN_W-1:0]    r_len_mem [MAX_LINES];
    logic [BYTE_W-1:0]   r_byte_q;
    logic [LEN_W-1:0]    r_len_q;

    logic                store_we, store_re;
    logic                len_we, len_re;
    logic [LEN_W-1:0]    len_wdata;
    logic [SLOT_W-1:0]   len_raddr;

    logic [SLOT_W-1:0]   ws_inc, slot_inc;
    logic [OFF_W:0]      fill_inc;
    logic                push_close;
    logic [CNT_W-1:0]    seen_inc;
    logic [CNT_W-1:0]    n_pick, n_take;
    logic [SLOT_W:0]     start_sum;
    logic [SLOT_W-1:0]   start_slot;
    logic                byte_end;

    assign ws_inc   = (r_ws == SLOT_W'(MAX_LINES - 1)) ? '0 : r_ws + 1'b1;
    assign slot_inc = (r_slot == SLOT_W'(MAX_LINES - 1)) ? '0 : r_slot + 1'b1;
    assign fill_inc = {1'b0, r_fill} + 1'b1;
    assign push_close = (i_cmd.data == NEWLINE_BYTE) ||
                        (fill_inc >= (OFF_W+1)'(LINE_LEN - 1));
    assign seen_inc = (r_seen == CNT_W'(MAX_LINES)) ? r_seen : r_seen + 1'b1;

    // replay count: out-of-range register means all lines, capped by lines seen
    assign n_pick = ((i_show == '0) || (32'(i_show) > 32'(MAX_LINES))) ?
                    CNT_W'(MAX_LINES) : CNT_W'(i_show);
    assign n_take = (n_pick > r_seen) ? r_seen : n_pick;

    // oldest replayed slot: (write_slot - n) mod MAX_LINES
    assign start_sum  = (SLOT_W+1)'(r_ws) + (SLOT_W+1)'(MAX_LINES) -
                        (SLOT_W+1)'(n_take);
    assign start_slot = (start_sum >= (SLOT_W+1)'(MAX_LINES)) ?
                        SLOT_W'(start_sum - (SLOT_W+1)'(MAX_LINES)) :
                        SLOT_W'(start_sum);

    assign byte_end = ((9)'(r_off) + 9'd1) >= {1'b0, r_cur_len};

    assign o_valid = (r_state == S_OUT);
    assign o_res   = r_res;

    always_comb begin
        n_state     = r_state;
        n_ws        = r_ws;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_active    = r_active;
        n_slot      = r_slot;
        n_off       = r_off;
        n_rem       = r_rem;
        n_cur_len   = r_cur_len;
        n_res       = r_res;
        o_cmd_ready = 1'b0;
        store_we    = 1'b0;
        store_re    = 1'b0;
        len_we      = 1'b0;
        len_re      = 1'b0;
        len_wdata   = LEN_W'(fill_inc);
        len_raddr   = start_slot;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_ready = 1'b1;
                    if (!i_cmd.is_pull) begin
                        // push cancels any replay
                        n_active = 1'b0;
                        n_rem    = '0;
                        store_we = 1'b1;
                        if (push_close) begin
                            len_we    = 1'b1;
                            len_wdata = LEN_W'(fill_inc);
                            n_ws      = ws_inc;
                            n_fill    = '0;
                            n_seen    = seen_inc;
                        end else begin
                            n_fill = OFF_W'(fill_inc);
                        end
                    end else if (r_active) begin
                        if (r_rem == '0) begin
                            n_res   = '{out_byte: '0, has_byte: 1'b0, last_byte: 1'b0};
                            n_state = S_OUT;
                        end else begin
                            store_re = 1'b1;
                            n_state  = S_BYTE;
                        end
                    end else begin
                        // first pull closes a pending partial line
                        if (r_fill != '0) begin
                            len_we    = 1'b1;
                            len_wdata = LEN_W'(r_fill);
                            n_ws      = ws_inc;
                            n_fill    = '0;
                            n_seen    = seen_inc;
                        end
                        n_state = S_OPEN;
                    end
                end
            end
            S_OPEN: begin
                n_slot   = start_slot;
                n_off    = '0;
                n_rem    = n_take;
                n_active = 1'b1;
                if (n_take == '0) begin
                    n_res   = '{out_byte: '0, has_byte: 1'b0, last_byte: 1'b0};
                    n_state = S_OUT;
                end else begin
                    len_re    = 1'b1;
                    len_raddr = start_slot;
                    n_state   = S_LEN_START;
                end
            end
            S_LEN_START: begin
                n_cur_len = r_len_q;
                store_re  = 1'b1;
                n_state   = S_BYTE;
            end
            S_BYTE: begin
                n_res.out_byte = r_byte_q;
                n_res.has_byte = 1'b1;
                if (byte_end) begin
                    n_slot          = slot_inc;
                    n_off           = '0;
                    n_rem           = r_rem - 1'b1;
                    n_res.last_byte = (r_rem == CNT_W'(1));
                    if (r_rem != CNT_W'(1)) begin
                        len_re    = 1'b1;
                        len_raddr = slot_inc;
                        n_state   = S_LEN_NEXT;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_off           = r_off + 1'b1;
                    n_res.last_byte = 1'b0;
                    n_state         = S_OUT;
                end
            end
            S_LEN_NEXT: begin
                n_cur_len = r_len_q;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ws     <= '0;
            r_fill   <= '0;
            r_seen   <= '0;
            r_active <= 1'b0;
            r_slot   <= '0;
            r_off    <= '0;
            r_rem    <= '0;
        end else begin
            r_state  <= n_state;
            r_ws     <= n_ws;
            r_fill   <= n_fill;
            r_seen   <= n_seen;
            r_active <= n_active;
            r_slot   <= n_slot;
            r_off    <= n_off;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_len <= n_cur_len;
        r_res     <= n_res;
    end

    // line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[ADDR_W'({r_ws, r_fill})] <= i_cmd.data;
        end
        if (store_re) begin
            r_byte_q <= r_store[ADDR_W'({r_slot, r_off})];
        end
    end

    // slot lengths
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[r_ws] <= len_wdata;
        end
        if (len_re) begin
            r_len_q <= r_len_mem[len_raddr];
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < OFF_W'(LINE_LEN - 1))
        else $error("partial line exceeds line length");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= r_seen)
        else $error("replay count exceeds stored lines");
    a_byte_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BYTE) |-> (r_active && (r_rem != '0)))
        else $error("byte fetched without a live replay");
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_res.has_byte) |-> (!r_res.last_byte && (r_res.out_byte == '0)))
        else $error("empty reply carries data");
`endif

endmodule

`default_nettype wire
